### rtl/core/i8080alu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080alu_pkg: shared types and constants of the 8080 accumulator ALU
// Operation codes, flag byte layout and the result record of the execute
// logic.
// ----------------------------------------------------------------------------
package i8080alu_pkg;

  localparam int unsigned OpW   = 5;
  localparam int unsigned ByteW = 8;

  typedef enum logic [OpW-1:0] {
    OP_ADD       = 5'd0,
    OP_ADC       = 5'd1,
    OP_SUB       = 5'd2,
    OP_SBB       = 5'd3,
    OP_AND       = 5'd4,
    OP_XOR       = 5'd5,
    OP_OR        = 5'd6,
    OP_CMP       = 5'd7,
    OP_RLC       = 5'd8,
    OP_RRC       = 5'd9,
    OP_RAL       = 5'd10,
    OP_RAR       = 5'd11,
    OP_CMA       = 5'd12,
    OP_CMC       = 5'd13,
    OP_STC       = 5'd14,
    OP_INR       = 5'd15,
    OP_DCR       = 5'd16,
    OP_LOAD_ACC  = 5'd17,
    OP_LOAD_FLAG = 5'd18
  } op_e;

  // flag byte: bit7 S, bit6 Z, bit4 AC, bit2 P, bit1 one, bit0 CY
  localparam logic [ByteW-1:0] FlagOne      = 8'h02;
  localparam logic [ByteW-1:0] FlagKeepMask = 8'hD5;
  localparam logic [ByteW-1:0] FlagReset    = 8'h02;
  localparam int unsigned      FlagCyBit    = 0;

  typedef struct packed {
    logic [ByteW-1:0] result;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] flags;
  } exec_res_t;

  // S, Z and P from the value, AC and CY as given, bit 1 set
  function automatic logic [ByteW-1:0] make_flags(logic [ByteW-1:0] v, logic ac,
                                                  logic cy);
    make_flags = {v[7], (v == '0), 1'b0, ac, 1'b0, ~^v, 1'b1, cy};
  endfunction

endpackage

### rtl/core/i8080alu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080alu_exec: combinational execute logic
// Computes the new accumulator, flag byte and result for one operation.
// ----------------------------------------------------------------------------
module i8080alu_exec (
  input  logic [i8080alu_pkg::OpW-1:0]   op_i,
  input  logic [i8080alu_pkg::ByteW-1:0] operand_i,
  input  logic [i8080alu_pkg::ByteW-1:0] acc_i,
  input  logic [i8080alu_pkg::ByteW-1:0] flags_i,
  output i8080alu_pkg::exec_res_t        res_o
);
  import i8080alu_pkg::*;

  op_e              op;
  logic             cy;
  logic             is_sub;
  logic             use_cy;
  logic             cin;
  logic [ByteW-1:0] add_b;
  logic [ByteW:0]   sum;
  logic [4:0]       low_sum;
  logic [ByteW-1:0] add_flags;
  logic [ByteW-1:0] logic_val;
  logic [ByteW-1:0] inr_val;
  logic [ByteW-1:0] dcr_val;

  assign op     = op_e'(op_i);
  assign cy     = flags_i[FlagCyBit];
  assign is_sub = (op == OP_SUB) || (op == OP_SBB) || (op == OP_CMP);
  assign use_cy = (op == OP_ADC) || (op == OP_SBB);
  // subtraction runs as A + ~B + not borrow
  assign add_b  = is_sub ? ~operand_i : operand_i;
  assign cin    = (use_cy & cy) ^ is_sub;

  assign sum       = {1'b0, acc_i} + {1'b0, add_b} + {{ByteW{1'b0}}, cin};
  assign low_sum   = {1'b0, acc_i[3:0]} + {1'b0, add_b[3:0]} + {4'b0000, cin};
  assign add_flags = make_flags(sum[ByteW-1:0], low_sum[4], sum[ByteW] ^ is_sub);

  assign inr_val = operand_i + 8'd1;
  assign dcr_val = operand_i - 8'd1;

  always_comb begin
    logic_val    = '0;
    res_o.acc    = acc_i;
    res_o.flags  = flags_i;
    unique case (op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB: begin
        res_o.acc   = sum[ByteW-1:0];
        res_o.flags = add_flags;
      end
      OP_CMP: res_o.flags = add_flags;
      OP_AND: begin
        logic_val   = acc_i & operand_i;
        res_o.acc   = logic_val;
        res_o.flags = make_flags(logic_val, acc_i[3] | operand_i[3], 1'b0);
      end
      OP_XOR: begin
        logic_val   = acc_i ^ operand_i;
        res_o.acc   = logic_val;
        res_o.flags = make_flags(logic_val, 1'b0, 1'b0);
      end
      OP_OR: begin
        logic_val   = acc_i | operand_i;
        res_o.acc   = logic_val;
        res_o.flags = make_flags(logic_val, 1'b0, 1'b0);
      end
      OP_RLC: begin
        res_o.acc              = {acc_i[ByteW-2:0], acc_i[ByteW-1]};
        res_o.flags[FlagCyBit] = acc_i[ByteW-1];
      end
      OP_RRC: begin
        res_o.acc              = {acc_i[0], acc_i[ByteW-1:1]};
        res_o.flags[FlagCyBit] = acc_i[0];
      end
      OP_RAL: begin
        res_o.acc              = {acc_i[ByteW-2:0], cy};
        res_o.flags[FlagCyBit] = acc_i[ByteW-1];
      end
      OP_RAR: begin
        res_o.acc              = {cy, acc_i[ByteW-1:1]};
        res_o.flags[FlagCyBit] = acc_i[0];
      end
      OP_CMA:       res_o.acc              = ~acc_i;
      OP_CMC:       res_o.flags[FlagCyBit] = ~cy;
      OP_STC:       res_o.flags[FlagCyBit] = 1'b1;
      OP_INR:       res_o.flags = make_flags(inr_val, operand_i[3:0] == 4'hF, cy);
      OP_DCR:       res_o.flags = make_flags(dcr_val, operand_i[3:0] != 4'h0, cy);
      OP_LOAD_ACC:  res_o.acc   = operand_i;
      OP_LOAD_FLAG: res_o.flags = (operand_i & FlagKeepMask) | FlagOne;
      default: begin
        res_o.acc   = acc_i;
        res_o.flags = flags_i;
      end
    endcase

    // inr and dcr return the new operand value, all else the accumulator
    unique case (op)
      OP_INR:  res_o.result = inr_val;
      OP_DCR:  res_o.result = dcr_val;
      default: res_o.result = res_o.acc;
    endcase
  end

endmodule

### rtl/core/i8080_accumulator_flag_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080_accumulator_flag_alu: 8080 accumulator and flag unit
// Executes accumulator-class operations against a kept A and PSW.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one operation per transfer (op code and an
//   operand byte). The master stream returns one transfer per operation:
//   the result byte, the accumulator after it and the flag byte.
//   An accepted transfer is held in the input register, then passes through
//   the execute logic into the result register, which drives the master
//   side. Throughput is one operation per cycle while the receiver does not
//   stall; the accumulator and flags are written in the same edge that loads
//   the result register, so the next operation sees them at once.
//   When the receiver stalls, the result register holds, the input register
//   holds behind it, and tready falls once both are full. No transfer is
//   dropped or repeated.
//   Reset clears both stream valids, sets the accumulator to zero and the
//   flag byte to 0x02 (bit 1 set).
// ----------------------------------------------------------------------------
module i8080_accumulator_flag_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [4:0] op, [12:5] operand, [15:13] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // [7:0] result, [15:8] acc_out, [23:16] psw_flags
);
  import i8080alu_pkg::*;

  logic             in_valid_q;
  logic [OpW-1:0]   op_q;
  logic [ByteW-1:0] operand_q;
  logic             out_valid_q;
  exec_res_t        out_q;
  logic [ByteW-1:0] acc_q;
  logic [ByteW-1:0] flags_q;
  exec_res_t        exec_res;
  logic             advance;
  logic             in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  i8080alu_exec u_exec (
    .op_i      (op_q),
    .operand_i (operand_q),
    .acc_i     (acc_q),
    .flags_i   (flags_q),
    .res_o     (exec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      flags_q     <= FlagReset;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        acc_q       <= exec_res.acc;
        flags_q     <= exec_res.flags;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q      <= s_axis_tdata_i[OpW-1:0];
      operand_q <= s_axis_tdata_i[OpW+ByteW-1:OpW];
    end
    if (advance) begin
      out_q <= exec_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.flags, out_q.acc, out_q.result};

  a_flag_fixed_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q[1] && !flags_q[3] && !flags_q[5])
    else $error("flag byte fixed bits corrupted");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid_o && (m_axis_tdata_o[15:8] == acc_q)
                && (m_axis_tdata_o[23:16] == flags_q))
    else $error("result register out of step with state");

  a_incdec_keeps_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ((op_q == OP_INR) || (op_q == OP_DCR))) |=> acc_q == $past(acc_q))
    else $error("inr/dcr altered the accumulator");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(acc_q) && $stable(flags_q))
    else $error("state changed without an operation");

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with free space");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 8080 accumulator and flag unit
// Streams operations into the block and predicts the accumulator and flag
// byte of each one. The first operations are directed at the corner cases;
// random operations with random sender gaps and receiver stalls follow.
// Every result transfer is compared field by field with the prediction.
// ----------------------------------------------------------------------------
module tb;
  import i8080alu_pkg::*;

  localparam logic [OpW-1:0] OpUnusedLo = 5'd19;
  localparam logic [OpW-1:0] OpUnusedHi = 5'd31;
  localparam int unsigned BitS  = 7;
  localparam int unsigned BitZ  = 6;
  localparam int unsigned BitAc = 4;
  localparam int unsigned BitP  = 2;
  localparam int unsigned RandomOps     = 1200;
  localparam int unsigned QuietTail     = 150;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 10;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] operand;
    bit               drain_first;  // hold until every result is back
  } alu_op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;

  alu_op_t     ops_to_send[$];
  exec_res_t   due_results[$];
  logic [ByteW-1:0] acc_m = '0;
  logic [ByteW-1:0] flags_m = FlagReset;
  int unsigned total_ops = 0;
  int unsigned taken_ops = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          in_taken = 1'b0;

  i8080_accumulator_flag_alu u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [ByteW-1:0] szp_bits(logic [ByteW-1:0] v);
    logic [ByteW-1:0] f;
    f        = '0;
    f[BitS]  = v[7];
    f[BitZ]  = (v == 8'h00);
    f[BitP]  = ~^v;
    return f;
  endfunction

  // Execute one operation on the modelled accumulator and flag byte
  task automatic alu_exec(input logic [OpW-1:0] op, input logic [ByteW-1:0] b,
                          output exec_res_t r);
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] f;
    logic [ByteW-1:0] addend;
    logic [ByteW-1:0] res;
    logic [8:0]       sum;
    logic [4:0]       nib;
    logic             cy;
    logic             cin;
    logic             is_sub;
    logic             on_operand;
    a          = acc_m;
    f          = flags_m;
    cy         = f[FlagCyBit];
    res        = '0;
    on_operand = 1'b0;
    case (op_e'(op))
      OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_CMP: begin
        // subtraction adds the complement; carry out inverts into a borrow
        is_sub = (op_e'(op) == OP_SUB) || (op_e'(op) == OP_SBB) || (op_e'(op) == OP_CMP);
        cin    = ((op_e'(op) == OP_ADC) || (op_e'(op) == OP_SBB)) ? cy : 1'b0;
        addend = is_sub ? ~b : b;
        cin    = is_sub ? ~cin : cin;
        sum    = {1'b0, a} + {1'b0, addend} + {8'h00, cin};
        nib    = {1'b0, a[3:0]} + {1'b0, addend[3:0]} + {4'h0, cin};
        f      = szp_bits(sum[7:0]) | FlagOne;
        f[BitAc]     = nib[4];
        f[FlagCyBit] = sum[8] ^ is_sub;
        if (op_e'(op) != OP_CMP) a = sum[7:0];
      end
      OP_AND: begin
        f        = szp_bits(a & b) | FlagOne;
        f[BitAc] = a[3] | b[3];
        a        = a & b;
      end
      OP_XOR: begin
        a = a ^ b;
        f = szp_bits(a) | FlagOne;
      end
      OP_OR: begin
        a = a | b;
        f = szp_bits(a) | FlagOne;
      end
      OP_RLC: begin
        f[FlagCyBit] = a[7];
        a = {a[6:0], a[7]};
      end
      OP_RRC: begin
        f[FlagCyBit] = a[0];
        a = {a[0], a[7:1]};
      end
      OP_RAL: begin
        f[FlagCyBit] = a[7];
        a = {a[6:0], cy};
      end
      OP_RAR: begin
        f[FlagCyBit] = a[0];
        a = {cy, a[7:1]};
      end
      OP_CMA: a = ~a;
      OP_CMC: f[FlagCyBit] = ~f[FlagCyBit];
      OP_STC: f[FlagCyBit] = 1'b1;
      OP_INR: begin
        res          = b + 8'd1;
        f            = szp_bits(res) | FlagOne;
        f[BitAc]     = (b[3:0] == 4'hF);
        f[FlagCyBit] = cy;
        on_operand   = 1'b1;
      end
      OP_DCR: begin
        res          = b - 8'd1;
        f            = szp_bits(res) | FlagOne;
        f[BitAc]     = (b[3:0] != 4'h0);
        f[FlagCyBit] = cy;
        on_operand   = 1'b1;
      end
      OP_LOAD_ACC:  a = b;
      OP_LOAD_FLAG: f = (b & FlagKeepMask) | FlagOne;
      default: ;
    endcase
    acc_m    = a;
    flags_m  = f;
    r.result = on_operand ? res : a;
    r.acc    = a;
    r.flags  = f;
  endtask

  task automatic queue_op(input logic [OpW-1:0] op, input logic [ByteW-1:0] operand,
                          input bit drain_first);
    alu_op_t it;
    it.op          = op;
    it.operand     = operand;
    it.drain_first = drain_first;
    ops_to_send.push_back(it);
  endtask

  // no idling near the end and in every fourth block of a hundred operations
  function automatic bit no_idle();
    return (taken_ops + QuietTail >= total_ops) || ((taken_ops / 100) % 4 == 3);
  endfunction

  // Sender: hold tvalid until the transfer, then advance or pause
  always @(negedge clk_i) begin : drive_ops
    logic        nxt_valid;
    logic [15:0] nxt_data;
    alu_op_t     it;
    nxt_valid = s_valid;
    nxt_data  = s_data;
    if (rst_ni) begin
      if (s_valid && in_taken) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (ops_to_send.size() > 0 &&
                     !(ops_to_send[0].drain_first && due_results.size() > 0)) begin
          it        = ops_to_send.pop_front();
          nxt_data  = {3'b000, it.operand, it.op};
          nxt_valid = 1'b1;
          if (!no_idle() && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
        end
      end
    end
    s_valid <= nxt_valid;
    s_data  <= nxt_data;
  end

  // Receiver: random stall bursts
  always @(negedge clk_i) begin : drive_ready
    if (stall_left == 0 && !no_idle() && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 15);
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Check results, predict on each input transfer, watch for a hang
  always @(posedge clk_i) begin : watch_streams
    exec_res_t want;
    exec_res_t got;
    bit        out_fire;
    out_fire = m_valid && m_ready;
    in_taken = s_valid && s_ready;
    if (out_fire) begin
      got.result = m_data[7:0];
      got.acc    = m_data[15:8];
      got.flags  = m_data[23:16];
      if (due_results.size() == 0) begin
        $error("result transfer with none outstanding: tdata %06h", m_data);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (got.result !== want.result) begin
          $error("result mismatch: expected %02h, actual %02h", want.result, got.result);
          fail_count++;
        end
        if (got.acc !== want.acc) begin
          $error("acc_out mismatch: expected %02h, actual %02h", want.acc, got.acc);
          fail_count++;
        end
        if (got.flags !== want.flags) begin
          $error("psw_flags mismatch: expected %02h, actual %02h", want.flags, got.flags);
          fail_count++;
        end
      end
    end
    if (in_taken) begin
      alu_exec(s_data[4:0], s_data[12:5], want);
      due_results.push_back(want);
      taken_ops++;
    end
    if (rst_ni) begin
      if (in_taken || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [OpW-1:0]   op;
    logic [ByteW-1:0] operand;
    // corner cases: carry and borrow chains, flag load masking, nibble wrap
    queue_op(OP_LOAD_FLAG, 8'hFF, 1'b0);
    queue_op(OP_LOAD_ACC,  8'hFF, 1'b0);
    queue_op(OP_ADC,       8'h01, 1'b0);
    queue_op(OP_ADD,       8'hFF, 1'b0);
    queue_op(OP_SUB,       8'hFF, 1'b0);
    queue_op(OP_SBB,       8'h00, 1'b0);
    queue_op(OP_CMP,       8'h80, 1'b0);
    queue_op(OP_AND,       8'h08, 1'b0);
    queue_op(OP_XOR,       8'hFF, 1'b0);
    queue_op(OP_OR,        8'h00, 1'b0);
    queue_op(OP_RLC,       8'h00, 1'b0);
    queue_op(OP_RRC,       8'h00, 1'b0);
    queue_op(OP_STC,       8'h00, 1'b0);
    queue_op(OP_RAL,       8'h00, 1'b0);
    queue_op(OP_RAR,       8'h00, 1'b0);
    queue_op(OP_CMA,       8'h00, 1'b0);
    queue_op(OP_CMC,       8'h00, 1'b0);
    queue_op(OP_INR,       8'hFF, 1'b0);
    queue_op(OP_INR,       8'h0F, 1'b0);
    queue_op(OP_DCR,       8'h00, 1'b0);
    queue_op(OP_DCR,       8'h10, 1'b0);
    queue_op(OpUnusedLo,   8'hAA, 1'b0);
    queue_op(OpUnusedHi,   8'h55, 1'b0);
    queue_op(OP_LOAD_FLAG, 8'h00, 1'b0);
    queue_op(OP_LOAD_ACC,  8'h00, 1'b0);
    for (int i = 0; i < RandomOps; i++) begin
      if ($urandom_range(0, 99) < 6) op = OpW'($urandom_range(OpUnusedLo, OpUnusedHi));
      else op = OpW'($urandom_range(0, OP_LOAD_FLAG));
      case ($urandom_range(0, 9))
        0:       operand = 8'h00;
        1:       operand = 8'hFF;
        2:       operand = {4'($urandom_range(0, 15)), 4'hF};
        3:       operand = {4'($urandom_range(0, 15)), 4'h0};
        default: operand = ByteW'($urandom_range(0, 255));
      endcase
      queue_op(op, operand, (i == 400) || (i == 800));
    end
    total_ops = ops_to_send.size();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (ops_to_send.size() > 0 || s_valid || due_results.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/i8080alu_pkg.sv
rtl/core/i8080alu_exec.sv
rtl/core/i8080_accumulator_flag_alu.sv
tb/tb.sv
